@@ sv/frm_pkg.sv @@
// Shared types, constants and codes of the frame rate meter.
`timescale 1ns / 1ps

package frm_pkg;

  // Time base and stamp arithmetic
  localparam int TICKS_PER_SECOND = 1000000;
  localparam int STAMP_W          = 48;
  localparam int FIELD_W          = 48;   // width of stamp fields at the ports
  localparam int CFG_W            = 48;   // width of the config write data
  localparam int PERIOD_W         = 24;
  localparam int CLAMP_W          = PERIOD_W + 1;
  localparam int FRAMES_W         = 32;
  localparam int MULT_W           = 16;
  localparam int MULT_FRAC        = 14;
  localparam int RATE_W           = 24;
  localparam int RATE_FRAC        = 8;

  // Divider sizing
  localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int PROD_W = FRAMES_W + TPS_W;
  localparam int NUM_W  = PROD_W + RATE_FRAC;
  localparam int DEN_W  = (STAMP_W > CFG_W) ? STAMP_W : CFG_W;
  localparam int QUO_W  = RATE_W;
  localparam int CNT_W  = $clog2(QUO_W + 1);
  localparam int CMP_W  = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  localparam logic [MULT_W-1:0] MULT_ONE = MULT_W'(1 << MULT_FRAC);
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  // Config register reset values
  localparam logic [CFG_W-1:0]    AVG_WIN_RESET = CFG_W'(500000);
  localparam logic [CFG_W-1:0]    LOG_WIN_RESET = CFG_W'(5000000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET  = PERIOD_W'(16667);

  // Config register indexes
  localparam logic [1:0] CFG_AVG_WIN = 2'd0;
  localparam logic [1:0] CFG_LOG_WIN = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;

  // Event kinds
  typedef enum logic [1:0] {
    ACT_FRAME   = 2'd0,
    ACT_SUSPEND = 2'd1,
    ACT_RESUME  = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic [FIELD_W-1:0] now_ticks;
  } frm_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  frame_interval_ticks;
    logic [MULT_W-1:0]   time_mult_q14;
    logic [RATE_W-1:0]   fps_q8;
    logic                fps_updated;
    logic [FIELD_W-1:0]  suspension_ticks;
    logic [FRAMES_W-1:0] total_frames;
  } frm_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic eval;
    logic mult_update;
    logic rate_mul;
    logic rate_start;
    logic rate_update;
    logic load_out;
  } frm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_frame;
    logic div_busy;
    logic rate_fire;
  } frm_stat_t;

endpackage

@@ sv/frm_div.sv @@
// Restoring divider, one quotient bit per cycle, with overflow flag.
`timescale 1ns / 1ps

module frm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [frm_pkg::NUM_W-1:0]   num,
  input  logic [frm_pkg::DEN_W-1:0]   den,
  output logic                        busy,
  output logic                        sat,
  output logic [frm_pkg::QUO_W-1:0]   quo
);

  logic [frm_pkg::CNT_W-1:0] cnt;
  logic [frm_pkg::DEN_W-1:0] rem;
  logic [frm_pkg::DEN_W-1:0] den_reg;
  logic [frm_pkg::QUO_W-1:0] num_sh;
  logic [frm_pkg::NUM_W-1:0] hi;
  logic [frm_pkg::DEN_W:0]   trial;
  logic                      ge;

  assign hi    = num >> frm_pkg::QUO_W;
  assign trial = {rem, num_sh[frm_pkg::QUO_W-1]};
  assign ge    = trial >= {1'b0, den_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      cnt     <= frm_pkg::CNT_W'(frm_pkg::QUO_W);
      // quotient has no room when the high part already reaches the divisor
      sat     <= frm_pkg::CMP_W'(hi) >= frm_pkg::CMP_W'(den);
      rem     <= frm_pkg::DEN_W'(hi);
      den_reg <= den;
      num_sh  <= num[frm_pkg::QUO_W-1:0];
    end else if (busy) begin
      rem    <= ge ? frm_pkg::DEN_W'(trial - {1'b0, den_reg}) : frm_pkg::DEN_W'(trial);
      quo    <= {quo[frm_pkg::QUO_W-2:0], ge};
      num_sh <= {num_sh[frm_pkg::QUO_W-2:0], 1'b0};
      cnt    <= cnt - 1'b1;
      if (cnt == frm_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ sv/frm_datapath.sv @@
// Datapath: config registers, timing state, divider and result register.
`timescale 1ns / 1ps

module frm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [1:0]                  cfg_index,
  input  logic [frm_pkg::CFG_W-1:0]   cfg_data,
  input  frm_pkg::frm_in_t            in_data,
  input  frm_pkg::frm_cmd_t           cmd,
  output frm_pkg::frm_stat_t          stat,
  output frm_pkg::frm_out_t           out_data
);

  // config
  logic [frm_pkg::CFG_W-1:0]    avg_win;
  logic [frm_pkg::CFG_W-1:0]    log_win;
  logic [frm_pkg::PERIOD_W-1:0] period;

  // architectural state
  logic [frm_pkg::STAMP_W-1:0]  frame_start;
  logic [frm_pkg::STAMP_W-1:0]  avg_origin;
  logic [frm_pkg::STAMP_W-1:0]  log_origin;
  logic [frm_pkg::STAMP_W-1:0]  suspend_start;
  logic [frm_pkg::FRAMES_W-1:0] avg_frames;
  logic [frm_pkg::FRAMES_W-1:0] log_frames;
  logic [frm_pkg::FRAMES_W-1:0] frame_total;
  logic [frm_pkg::MULT_W-1:0]   mult_now;
  logic [frm_pkg::MULT_W-1:0]   mult_before;
  logic [frm_pkg::RATE_W-1:0]   rate_now;

  // per-item working registers
  logic [1:0]                   act;
  logic [frm_pkg::STAMP_W-1:0]  now;
  logic [frm_pkg::STAMP_W-1:0]  interval_reg;
  logic [frm_pkg::STAMP_W-1:0]  susp_reg;
  logic [frm_pkg::STAMP_W-1:0]  elapsed_avg_reg;
  logic                         avg_fire;
  logic                         log_fire;
  logic                         updated;
  logic [frm_pkg::PROD_W-1:0]   prod;

  // combinational
  logic [frm_pkg::STAMP_W-1:0]  interval;
  logic [frm_pkg::STAMP_W-1:0]  elapsed_avg;
  logic [frm_pkg::STAMP_W-1:0]  elapsed_log;
  logic [frm_pkg::STAMP_W-1:0]  susp;
  logic [frm_pkg::PERIOD_W-1:0] p_eff;
  logic [frm_pkg::CLAMP_W-1:0]  two_p;
  logic [frm_pkg::CLAMP_W-1:0]  clamped;
  logic                         is_frame;
  logic                         avg_hit;
  logic                         log_hit;
  logic [frm_pkg::FRAMES_W-1:0] avg_frames_inc;
  logic [frm_pkg::MULT_W+1:0]   mult_sum;
  logic [frm_pkg::FRAMES_W-1:0] rate_frames;

  // divider
  logic                         div_start;
  logic [frm_pkg::NUM_W-1:0]    div_num;
  logic [frm_pkg::DEN_W-1:0]    div_den;
  logic                         div_busy;
  logic                         div_sat;
  logic [frm_pkg::QUO_W-1:0]    div_quo;

  assign is_frame    = act == frm_pkg::ACT_FRAME;
  assign interval    = now - frame_start;
  assign elapsed_avg = now - avg_origin;
  assign elapsed_log = now - log_origin;
  assign susp        = now - suspend_start;

  assign p_eff   = (period == '0) ? frm_pkg::PERIOD_W'(1) : period;
  assign two_p   = {p_eff, 1'b0};
  assign clamped = (interval < frm_pkg::STAMP_W'(two_p)) ?
                   frm_pkg::CLAMP_W'(interval) : two_p;

  assign avg_frames_inc = avg_frames + 1'b1;
  assign avg_hit = (avg_win != '0) &&
                   (frm_pkg::DEN_W'(elapsed_avg) > frm_pkg::DEN_W'(avg_win));
  // an average update zeroes the average count; it also takes priority and blocks the log update
  assign log_hit = !avg_hit && (log_win != '0) && (avg_frames_inc != '0) &&
                   (frm_pkg::DEN_W'(elapsed_log) > frm_pkg::DEN_W'(log_win));

  assign mult_sum = {1'b0, mult_before, 1'b0} + (frm_pkg::MULT_W+2)'(mult_now) +
                    (frm_pkg::MULT_W+2)'(div_quo);

  assign rate_frames = avg_fire ? avg_frames : log_frames;

  assign div_start = (cmd.eval && is_frame) || cmd.rate_start;
  always_comb begin
    if (cmd.rate_start) begin
      div_num = {prod, {frm_pkg::RATE_FRAC{1'b0}}};
      div_den = avg_fire ? frm_pkg::DEN_W'(elapsed_avg_reg) : frm_pkg::DEN_W'(log_win);
    end else begin
      div_num = frm_pkg::NUM_W'(clamped) << frm_pkg::MULT_FRAC;
      div_den = frm_pkg::DEN_W'(p_eff);
    end
  end

  frm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .sat   (div_sat),
    .quo   (div_quo)
  );

  assign stat.is_frame  = is_frame;
  assign stat.div_busy  = div_busy;
  assign stat.rate_fire = avg_fire || log_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_win       <= frm_pkg::AVG_WIN_RESET;
      log_win       <= frm_pkg::LOG_WIN_RESET;
      period        <= frm_pkg::PERIOD_RESET;
      frame_start   <= '0;
      avg_origin    <= '0;
      log_origin    <= '0;
      suspend_start <= '0;
      avg_frames    <= '0;
      log_frames    <= '0;
      frame_total   <= '0;
      mult_now      <= frm_pkg::MULT_ONE;
      mult_before   <= frm_pkg::MULT_ONE;
      rate_now      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          frm_pkg::CFG_AVG_WIN: avg_win <= cfg_data;
          frm_pkg::CFG_LOG_WIN: log_win <= cfg_data;
          frm_pkg::CFG_PERIOD:  period  <= cfg_data[frm_pkg::PERIOD_W-1:0];
          default: ;
        endcase
      end

      if (cmd.load_in) begin
        act <= in_data.action;
        now <= frm_pkg::STAMP_W'(in_data.now_ticks);
      end

      if (cmd.eval) begin
        interval_reg    <= is_frame ? interval : '0;
        susp_reg        <= (act == frm_pkg::ACT_RESUME) ? susp : '0;
        elapsed_avg_reg <= elapsed_avg;
        avg_fire        <= is_frame && avg_hit;
        log_fire        <= is_frame && log_hit;
        updated         <= 1'b0;
        unique case (act)
          frm_pkg::ACT_FRAME: begin
            frame_start <= now;
            frame_total <= frame_total + 1'b1;
            avg_frames  <= avg_frames_inc;
            log_frames  <= log_frames + 1'b1;
          end
          frm_pkg::ACT_SUSPEND: begin
            suspend_start <= now;
          end
          frm_pkg::ACT_RESUME: begin
            frame_start <= frame_start + susp;
            avg_origin  <= avg_origin + susp;
            log_origin  <= log_origin + susp;
          end
          default: ;
        endcase
      end

      if (cmd.mult_update) begin
        mult_now    <= mult_sum[frm_pkg::MULT_W+1:2];
        mult_before <= mult_now;
      end

      if (cmd.rate_mul) begin
        prod <= frm_pkg::PROD_W'(rate_frames) *
                frm_pkg::PROD_W'(frm_pkg::TICKS_PER_SECOND);
      end

      if (cmd.rate_update) begin
        rate_now <= div_sat ? frm_pkg::RATE_MAX : div_quo;
        updated  <= 1'b1;
        if (avg_fire) begin
          avg_frames <= '0;
          avg_origin <= now;
        end else begin
          log_frames <= '0;
          log_origin <= now;
        end
      end

      if (cmd.load_out) begin
        out_data.frame_interval_ticks <= frm_pkg::FIELD_W'(interval_reg);
        out_data.time_mult_q14        <= mult_now;
        out_data.fps_q8               <= rate_now;
        out_data.fps_updated          <= updated;
        out_data.suspension_ticks     <= frm_pkg::FIELD_W'(susp_reg);
        out_data.total_frames         <= frame_total;
      end
    end
  end

endmodule

@@ sv/frm_ctrl.sv @@
// Controller: sequences one event through the datapath and owns output valid.
`timescale 1ns / 1ps

module frm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  frm_pkg::frm_stat_t stat,
  output frm_pkg::frm_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV_RATIO,
    S_RATE_MUL,
    S_RATE_START,
    S_RATE_DIV,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = rst || (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd         = '0;
    state_next  = state;
    cmd.load_in = in_valid && !in_stall;
    unique case (state)
      S_IDLE: begin
        if (cmd.load_in) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = stat.is_frame ? S_DIV_RATIO : S_FINISH;
      end
      S_DIV_RATIO: begin
        if (!stat.div_busy) begin
          cmd.mult_update = 1'b1;
          state_next      = stat.rate_fire ? S_RATE_MUL : S_FINISH;
        end
      end
      S_RATE_MUL: begin
        cmd.rate_mul = 1'b1;
        state_next   = S_RATE_START;
      end
      S_RATE_START: begin
        cmd.rate_start = 1'b1;
        state_next     = S_RATE_DIV;
      end
      S_RATE_DIV: begin
        if (!stat.div_busy) begin
          cmd.rate_update = 1'b1;
          state_next      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ sv/frame_rate_meter_core.sv @@
// Top level of the frame rate meter: controller, datapath and checks.
`timescale 1ns / 1ps

// Frame rate meter. Each input item is an event (frame, suspend or resume) with
// a tick timestamp; every item yields exactly one result item. One event is
// worked on at a time. Suspend, resume and unknown events pass through EVAL
// and FINISH; a frame event also through DIV_RATIO, and one that recomputes
// the frame rate also RATE_MUL, RATE_START and RATE_DIV. The single shared
// restoring divider, which produces one quotient bit per cycle (24 bits),
// serves first the time multiplier ratio and then, when a window expires,
// the frame rate. The result sits in an output register, so the next
// event is taken while a finished result still waits downstream; the block
// holds in FINISH only when a new result is ready and the old one is unread.
// Config writes are always taken (cfg_ready is high out of reset) and must
// land only while no event is in flight. Register 0 is the average window,
// 1 the log window, 2 the nominal frame period; a zero period counts as one.
module frame_rate_meter_core (
  input  logic                        clk,
  input  logic                        rst,
  // event items
  input  logic                        in_valid,
  output logic                        in_stall,
  input  frm_pkg::frm_in_t            in_data,
  // result items
  output logic                        out_valid,
  input  logic                        out_stall,
  output frm_pkg::frm_out_t           out_data,
  // config writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [frm_pkg::CFG_W-1:0]   cfg_data
);

  frm_pkg::frm_cmd_t  cmd;
  frm_pkg::frm_stat_t stat;

  assign cfg_ready = !rst;

  frm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  frm_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

  // An accepted item keeps the input side closed for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // The divider is never running while the block waits for an item.
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !stat.div_busy)
    else $error("divider busy while idle");

  // The smoothed multiplier never exceeds 2.0 in Q2.14.
  a_mult_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.time_mult_q14 <= 16'd32768)
    else $error("time multiplier out of range");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid || !out_stall)
    else $error("result register overwritten");

endmodule
